FILE: sv/utd_pkg.sv
// shared types and constants for the utf-8 to utf-16 decoder
`timescale 1ns / 1ps
`default_nettype none
package utd_pkg;

  localparam int unsigned COUNT_MAX = 65535;
  localparam logic [15:0] COUNT_LIMIT = (COUNT_MAX < 65535) ? 16'(COUNT_MAX) : 16'hFFFF;

  typedef enum logic [1:0] {
    ST_CHAR  = 2'd0,
    ST_END   = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] code_unit;
    status_t     status;
    logic [15:0] char_count;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/utf8_to_utf16_decoder_unit.sv
// utf-8 to utf-16 decoder: input register, decode step, output register
// an accepted byte is held in the input register, and its result is then registered in the output register
// throughput: one byte per cycle while the output is not held, set by the combinational decode step in utd_core
// a held output stops intake once the input register is full
// reset (synchronous, rst_n low) clears both valid flags and all decoder state
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_utf16_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] code_unit, [31:16] char_count
  output logic [1:0]       out_tuser   // [1:0] status
);
  import utd_pkg::*;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_res_r;
  logic        advance;
  logic        res_valid;
  result_t     res;

  // the registered byte moves on whenever the output slot is free or emptying
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  utd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .byte_in   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.char_count, out_res_r.code_unit};
  assign out_tuser  = out_res_r.status;

endmodule
`default_nettype wire

FILE: sv/utd_core.sv
// decoder state and combinational next-state and result logic
`timescale 1ns / 1ps
`default_nettype none
module utd_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step_en,
  input  wire logic [7:0]      byte_in,
  output logic                 res_valid,
  output utd_pkg::result_t     res
);
  import utd_pkg::*;

  logic [1:0]  pending_r, pending_nxt;
  logic [15:0] partial_r, partial_nxt;
  logic [15:0] count_r, count_nxt;
  logic        skip_r, skip_nxt;

  logic [15:0] count_inc;
  logic [15:0] assembled;

  assign count_inc = (count_r < COUNT_LIMIT) ? count_r + 16'd1 : count_r;
  assign assembled = {partial_r[9:0], byte_in[5:0]};

  always_comb begin
    pending_nxt    = pending_r;
    partial_nxt    = partial_r;
    count_nxt      = count_r;
    skip_nxt       = skip_r;
    res_valid      = 1'b0;
    res.code_unit  = 16'd0;
    res.status     = ST_CHAR;
    res.char_count = count_r;
    if (skip_r) begin
      if (byte_in == 8'd0) begin
        skip_nxt    = 1'b0;
        pending_nxt = 2'd0;
        partial_nxt = 16'd0;
        count_nxt   = 16'd0;
      end
    end else if (pending_r != 2'd0) begin
      if (byte_in == 8'd0) begin
        res_valid   = 1'b1;
        res.status  = ST_ERROR;
        pending_nxt = 2'd0;
        partial_nxt = 16'd0;
        count_nxt   = 16'd0;
      end else if (pending_r == 2'd1) begin
        res_valid      = 1'b1;
        res.code_unit  = assembled;
        res.char_count = count_inc;
        count_nxt      = count_inc;
        pending_nxt    = 2'd0;
        partial_nxt    = 16'd0;
      end else begin
        partial_nxt = assembled;
        pending_nxt = pending_r - 2'd1;
      end
    end else if (byte_in == 8'd0) begin
      res_valid   = 1'b1;
      res.status  = ST_END;
      partial_nxt = 16'd0;
      count_nxt   = 16'd0;
    end else if (!byte_in[7]) begin
      res_valid      = 1'b1;
      res.code_unit  = {8'd0, byte_in};
      res.char_count = count_inc;
      count_nxt      = count_inc;
    end else if (byte_in[6] && !byte_in[5]) begin
      partial_nxt = {11'd0, byte_in[4:0]};
      pending_nxt = 2'd1;
    end else if (byte_in[6] && !byte_in[4]) begin
      partial_nxt = {12'd0, byte_in[3:0]};
      pending_nxt = 2'd2;
    end else begin
      // bad lead byte: report, then drop bytes until the terminator
      res_valid   = 1'b1;
      res.status  = ST_ERROR;
      pending_nxt = 2'd0;
      partial_nxt = 16'd0;
      count_nxt   = 16'd0;
      skip_nxt    = 1'b1;
    end
    if (!step_en) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
      partial_r <= 16'd0;
      count_r   <= 16'd0;
      skip_r    <= 1'b0;
    end else if (step_en) begin
      pending_r <= pending_nxt;
      partial_r <= partial_nxt;
      count_r   <= count_nxt;
      skip_r    <= skip_nxt;
    end
  end

endmodule
`default_nettype wire
